// ===== hdl/rls_pkg.sv =====
// Shared types, constants and helpers of the RLS predictor.
`default_nettype none
package rls_pkg;
	localparam int TAPS_DEF = 4;
	localparam int ACCW = 56;

	localparam logic signed [47:0] MAX48 = 48'sh7FFF_FFFF_FFFF;
	localparam logic signed [47:0] MIN48 = 48'sh8000_0000_0000;
	localparam logic signed [ACCW-1:0] MAX_A = ACCW'(MAX48);
	localparam logic signed [ACCW-1:0] MIN_A = ACCW'(MIN48);

	localparam logic [31:0] INV_FORGET_RST = 32'd1084587701;
	localparam logic [30:0] P_INIT_RST = 31'd6553600;
	localparam logic [15:0] WARMUP_RST = 16'd10;

	// multiplier operand pairs
	localparam logic [2:0] SEL_PH = 3'd0;
	localparam logic [2:0] SEL_ACCLAM = 3'd1;
	localparam logic [2:0] SEL_K0H = 3'd2;
	localparam logic [2:0] SEL_MUK0 = 3'd3;
	localparam logic [2:0] SEL_PLAM = 3'd4;
	localparam logic [2:0] SEL_K1K0 = 3'd5;
	localparam logic [2:0] SEL_E0K1 = 3'd6;
	localparam logic [2:0] SEL_WH = 3'd7;

	// product shift
	localparam logic [1:0] SH16 = 2'd0;
	localparam logic [1:0] SH30 = 2'd1;
	localparam logic [1:0] SH32 = 2'd2;

	typedef struct packed {
		logic       in_load;
		logic       acc_clr;
		logic       acc_add;
		logic       p_rd;
		logic       mul_go;
		logic [2:0] sel;
		logic       k0_wr;
		logic       div_go;
		logic       k1_wr;
		logic       t1_wr;
		logic       p_wr_lo;
		logic       p_wr_hi;
		logic       w_wr;
		logic       e0_wr;
		logic       hist_shift;
		logic       est_wr;
		logic       out_load;
	} cmd_t;

	typedef struct packed {
		logic mul_done;
		logic div_done;
		logic out_full;
	} stat_t;

	function automatic logic signed [47:0] sat48(input logic signed [ACCW-1:0] v);
		logic signed [47:0] r;
		if (v > MAX_A) r = MAX48;
		else if (v < MIN_A) r = MIN48;
		else r = v[47:0];
		return r;
	endfunction

	function automatic logic signed [ACCW-1:0] ext48(input logic signed [47:0] v);
		return {{(ACCW-48){v[47]}}, v};
	endfunction
endpackage
`default_nettype wire

// ===== hdl/rls_adaptive_predictor.sv =====
// Top level of the RLS adaptive predictor: register port, controller and datapath.
//
// One signed Q16.16 sample enters per word on the s_ channel; one word leaves
// on the m_ channel per sample: the Q16.16 forecast (clamped at zero) in
// m_tdata and the pass-through flag in m_tuser.
// Samples are processed one at a time: the next sample is accepted only after
// the result of the previous one has been loaded into the output register.
// Every product runs through one shared 24x24 multiplier, and the gain
// reciprocal comes from a bit-serial divider.
// s_tready is high only between samples. The result word sits in an output
// register; while the receiver stalls, the next sample is accepted and
// processed, and its result waits until the previous word is taken.
// Reset loads the register defaults, zeroes weights, history and estimate,
// and marks the matrix as holding its initial diagonal; writing p_init
// does the same for the matrix alone.
// Registers (APB, byte address): 0x0 inv_forgetting, 0x4 p_init,
// 0x8 warmup_steps. Write them only while no sample is in flight.
`default_nettype none
module rls_adaptive_predictor
	import rls_pkg::*;
#(
	parameter int TAPS = TAPS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,  // [31:0] sample
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,  // [30:0] forecast, [31] zero
	output logic             m_tuser   // [0] in_warmup
);
	localparam int IW = (TAPS > 1) ? $clog2(TAPS) : 1;
	localparam logic [1:0] REG_INV = 2'd0;
	localparam logic [1:0] REG_PINIT = 2'd1;
	localparam logic [1:0] REG_WARM = 2'd2;

	logic [31:0]   inv_forgetting_q;
	logic [30:0]   p_init_q;
	logic [15:0]   warmup_q;
	logic          wr, p_reload;
	cmd_t          cmd;
	stat_t         stat;
	logic [IW-1:0] i, j;

	assign pready = 1'b1;
	assign wr = psel & penable & pwrite & pready;
	assign p_reload = wr && paddr[3:2] == REG_PINIT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_forgetting_q <= INV_FORGET_RST;
			p_init_q <= P_INIT_RST;
			warmup_q <= WARMUP_RST;
		end else if (wr) begin
			case (paddr[3:2])
				REG_INV: inv_forgetting_q <= pwdata;
				REG_PINIT: p_init_q <= pwdata[30:0];
				REG_WARM: warmup_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_INV: prdata = inv_forgetting_q;
			REG_PINIT: prdata = {1'b0, p_init_q};
			REG_WARM: prdata = {16'b0, warmup_q};
			default: prdata = '0;
		endcase
	end

	rls_ctrl #(.TAPS(TAPS)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .rdy(s_tready),
		.stat(stat), .cmd(cmd), .i(i), .j(j)
	);

	rls_dp #(.TAPS(TAPS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .i(i), .j(j), .stat(stat),
		.inv_forgetting(inv_forgetting_q), .p_init(p_init_q), .warmup_steps(warmup_q),
		.p_reload(p_reload), .sample(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);
endmodule
`default_nettype wire

// ===== hdl/rls_mul.sv =====
// Multi-cycle 48x48 signed multiplier with rounding shift and 48-bit saturation.
`default_nettype none
module rls_mul
	import rls_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               go,
	input  wire logic signed [47:0] a,
	input  wire logic signed [47:0] b,
	input  wire logic [1:0]         sh,
	output logic                    done,
	output logic signed [47:0]      res
);
	logic [47:0] ua_q, ub_q;
	logic        neg_q;
	logic [1:0]  sh_q;
	logic [95:0] prod_q;
	logic [2:0]  step_q;
	logic        busy_q, done_q;
	logic signed [47:0] res_q;

	logic [23:0] opa, opb;
	logic [47:0] pp;
	logic [95:0] pp_sh, rnd, sum, r, lim;
	logic [47:0] r48;

	always_comb begin
		opa = step_q[1] ? ua_q[47:24] : ua_q[23:0];
		opb = step_q[0] ? ub_q[47:24] : ub_q[23:0];
		pp = 48'(opa * opb);
		case (step_q)
			3'd0: pp_sh = {48'b0, pp};
			3'd1, 3'd2: pp_sh = {24'b0, pp, 24'b0};
			default: pp_sh = {pp, 48'b0};
		endcase
		case (sh_q)
			SH16: rnd = 96'h8000;
			SH30: rnd = 96'h2000_0000;
			default: rnd = 96'h8000_0000;
		endcase
		sum = prod_q + rnd;
		case (sh_q)
			SH16: r = sum >> 16;
			SH30: r = sum >> 30;
			default: r = sum >> 32;
		endcase
		lim = neg_q ? 96'h8000_0000_0000 : 96'h7FFF_FFFF_FFFF;
		r48 = (r > lim) ? lim[47:0] : r[47:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (step_q == 3'd4) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q + 3'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			ua_q <= a[47] ? 48'(-a) : a;
			ub_q <= b[47] ? 48'(-b) : b;
			neg_q <= a[47] ^ b[47];
			sh_q <= sh;
			prod_q <= '0;
		end else if (busy_q) begin
			if (step_q == 3'd4) res_q <= neg_q ? -$signed(r48) : $signed(r48);
			else prod_q <= prod_q + pp_sh;
		end
	end

	assign done = done_q;
	assign res = res_q;
endmodule
`default_nettype wire

// ===== hdl/rls_div.sv =====
// Restoring divider giving 2^64 / d, saturated to the positive 48-bit range.
`default_nettype none
module rls_div
	import rls_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        go,
	input  wire logic [47:0] d,
	output logic             done,
	output logic [47:0]      q
);
	logic [47:0] d_q, q_q;
	logic [48:0] rem_q;
	logic [6:0]  cnt_q;
	logic        busy_q, done_q, small_q;
	logic [48:0] trial;
	logic        fit;

	always_comb begin
		trial = {rem_q[47:0], (cnt_q == 7'd0)};
		fit = trial >= {1'b0, d_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'd64) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			d_q <= d;
			small_q <= d < 48'h2_0000;
			rem_q <= '0;
			q_q <= '0;
		end else if (busy_q) begin
			rem_q <= fit ? trial - {1'b0, d_q} : trial;
			q_q <= {q_q[46:0], fit};
		end
	end

	assign done = done_q;
	assign q = (small_q || q_q[47]) ? MAX48 : q_q;
endmodule
`default_nettype wire

// ===== hdl/rls_dp.sv =====
// Datapath: matrix memory, vectors, accumulator, shared multiplier and divider, output word.
`default_nettype none
module rls_dp
	import rls_pkg::*;
#(
	parameter int TAPS = TAPS_DEF,
	localparam int IW = (TAPS > 1) ? $clog2(TAPS) : 1,
	localparam int AW = (TAPS > 1) ? $clog2(TAPS * TAPS) : 1
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire cmd_t          cmd,
	input  wire logic [IW-1:0] i,
	input  wire logic [IW-1:0] j,
	output stat_t              stat,
	input  wire logic [31:0]   inv_forgetting,
	input  wire logic [30:0]   p_init,
	input  wire logic [15:0]   warmup_steps,
	input  wire logic          p_reload,
	input  wire logic [31:0]   sample,
	output logic               m_tvalid,
	input  wire logic          m_tready,
	output logic [31:0]        m_tdata,
	output logic               m_tuser
);
	localparam int NP = TAPS * TAPS;
	localparam logic [AW-1:0] TAPS_A = AW'(TAPS);

	logic signed [47:0] pmem [NP];
	logic [NP-1:0]      pv_q;
	logic signed [47:0] prd_q;
	logic               prd_vld_q, prd_diag_q;

	logic signed [31:0] s_q;
	logic signed [31:0] h_q [TAPS];
	logic signed [47:0] k0_q [TAPS];
	logic signed [47:0] k1_q [TAPS];
	logic signed [47:0] w_q [TAPS];
	logic signed [47:0] mu_q, e0_q, t1_q, v_q, prior_q;
	logic signed [ACCW-1:0] acc_q;
	logic [15:0]        cnt_q;
	logic               den_neg_q;
	logic               mv_q, mu_user_q;
	logic [30:0]        fc_q;

	logic [AW-1:0]      a_ij, a_ji;
	logic signed [47:0] pval, hj, lam, ma, mb, mres, accs, v, nu;
	logic [1:0]         msh;
	logic               mdone, ddone;
	logic [47:0]        dq, dabs;
	logic signed [49:0] den;
	logic               warm;
	logic [47:0]        rnd_est;
	logic [30:0]        fc;

	always_comb begin
		a_ij = AW'(i) * TAPS_A + AW'(j);
		a_ji = AW'(j) * TAPS_A + AW'(i);
		pval = prd_vld_q ? prd_q : (prd_diag_q ? $signed({1'b0, p_init, 16'b0}) : 48'sd0);
		hj = {{16{h_q[j][31]}}, h_q[j]};
		lam = {16'b0, inv_forgetting};
		accs = sat48(acc_q);
		v = sat48(ext48(t1_q) - ext48(mres));
		nu = accs;
		den = {{2{nu[47]}}, nu} + 50'sh1_0000_0000;
		dabs = den[49] ? 48'(-den) : den[47:0];
		case (cmd.sel)
			SEL_PH: begin ma = pval; mb = hj; msh = SH16; end
			SEL_ACCLAM: begin ma = accs; mb = lam; msh = SH30; end
			SEL_K0H: begin ma = k0_q[j]; mb = hj; msh = SH16; end
			SEL_MUK0: begin ma = mu_q; mb = k0_q[j]; msh = SH32; end
			SEL_PLAM: begin ma = pval; mb = lam; msh = SH30; end
			SEL_K1K0: begin ma = k1_q[i]; mb = k0_q[j]; msh = SH32; end
			SEL_E0K1: begin ma = e0_q; mb = k1_q[i]; msh = SH32; end
			default: begin ma = w_q[i]; mb = hj; msh = SH16; end
		endcase
		warm = cnt_q < warmup_steps;
		rnd_est = 48'(prior_q) + 48'h8000;
		if (warm) fc = s_q[31] ? 31'd0 : s_q[30:0];
		else if (prior_q <= 48'sd0) fc = 31'd0;
		else if (rnd_est[47:16] > 32'h7FFF_FFFF) fc = 31'h7FFF_FFFF;
		else fc = rnd_est[46:16];
	end

	rls_mul u_mul (
		.clk(clk), .arst_n(arst_n), .go(cmd.mul_go), .a(ma), .b(mb), .sh(msh),
		.done(mdone), .res(mres)
	);

	rls_div u_div (
		.clk(clk), .arst_n(arst_n), .go(cmd.div_go), .d(dabs), .done(ddone), .q(dq)
	);

	always_ff @(posedge clk) begin
		if (cmd.p_wr_lo) pmem[a_ij] <= v;
		else if (cmd.p_wr_hi) pmem[a_ji] <= v_q;
		if (cmd.p_rd) begin
			prd_q <= pmem[a_ij];
			prd_vld_q <= pv_q[a_ij];
			prd_diag_q <= i == j;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_q <= '0;
		end else if (p_reload) begin
			pv_q <= '0;
		end else if (cmd.p_wr_lo) begin
			pv_q[a_ij] <= 1'b1;
		end else if (cmd.p_wr_hi) begin
			pv_q[a_ji] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.in_load) s_q <= sample;
		if (cmd.acc_clr) acc_q <= '0;
		else if (cmd.acc_add) acc_q <= acc_q + ext48(mres);
		if (cmd.k0_wr) k0_q[i] <= mres;
		if (cmd.k1_wr) k1_q[j] <= mres;
		if (cmd.t1_wr) t1_q <= mres;
		if (cmd.p_wr_lo) v_q <= v;
		if (cmd.div_go) den_neg_q <= den[49];
		if (ddone) mu_q <= den_neg_q ? -$signed(dq) : $signed(dq);
		if (cmd.e0_wr) e0_q <= sat48(ext48({s_q, 16'b0}) - ext48(prior_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < TAPS; k++) begin
				w_q[k] <= '0;
				h_q[k] <= '0;
			end
			prior_q <= '0;
			cnt_q <= '0;
			mv_q <= 1'b0;
		end else begin
			if (cmd.w_wr) w_q[i] <= sat48(ext48(w_q[i]) + ext48(mres));
			if (cmd.hist_shift) begin
				for (int k = TAPS - 1; k > 0; k--) h_q[k] <= h_q[k-1];
				h_q[0] <= s_q;
			end
			if (cmd.est_wr) prior_q <= accs;
			if (cmd.out_load) begin
				mv_q <= 1'b1;
				if (warm) cnt_q <= cnt_q + 16'd1;
			end else if (m_tready) begin
				mv_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			fc_q <= fc;
			mu_user_q <= warm;
		end
	end

	assign stat.mul_done = mdone;
	assign stat.div_done = ddone;
	assign stat.out_full = mv_q & ~m_tready;
	assign m_tvalid = mv_q;
	assign m_tdata = {1'b0, fc_q};
	assign m_tuser = mu_user_q;
endmodule
`default_nettype wire

// ===== hdl/rls_ctrl.sv =====
// Controller: sequences the per-word update steps over the shared units.
`default_nettype none
module rls_ctrl
	import rls_pkg::*;
#(
	parameter int TAPS = TAPS_DEF,
	localparam int IW = (TAPS > 1) ? $clog2(TAPS) : 1
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     s_tvalid,
	output logic          rdy,
	input  wire stat_t    stat,
	output cmd_t          cmd,
	output logic [IW-1:0] i,
	output logic [IW-1:0] j
);
	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_K0_RD = 4'd1;
	localparam logic [3:0] ST_K0_MUL = 4'd2;
	localparam logic [3:0] ST_K0_LAM = 4'd3;
	localparam logic [3:0] ST_NU = 4'd4;
	localparam logic [3:0] ST_DIV = 4'd5;
	localparam logic [3:0] ST_K1 = 4'd6;
	localparam logic [3:0] ST_PU_RD = 4'd7;
	localparam logic [3:0] ST_PU_M1 = 4'd8;
	localparam logic [3:0] ST_PU_M2 = 4'd9;
	localparam logic [3:0] ST_PU_WR2 = 4'd10;
	localparam logic [3:0] ST_E0 = 4'd11;
	localparam logic [3:0] ST_W = 4'd12;
	localparam logic [3:0] ST_EST = 4'd13;
	localparam logic [3:0] ST_FIN = 4'd14;
	localparam logic [3:0] ST_OUT = 4'd15;
	localparam logic [IW-1:0] LAST = IW'(TAPS - 1);

	logic [3:0]    st_q, st_d;
	logic          ph_q, ph_d;
	logic [IW-1:0] i_q, i_d, j_q, j_d;
	logic          li, lj;

	always_comb begin
		cmd = '0;
		st_d = st_q;
		ph_d = ph_q;
		i_d = i_q;
		j_d = j_q;
		li = i_q == LAST;
		lj = j_q == LAST;
		case (st_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.in_load = 1'b1;
					cmd.acc_clr = 1'b1;
					i_d = '0;
					j_d = '0;
					st_d = ST_K0_RD;
				end
			end
			ST_K0_RD: begin
				cmd.p_rd = 1'b1;
				st_d = ST_K0_MUL;
			end
			ST_K0_MUL: begin
				cmd.sel = SEL_PH;
				if (!ph_q) begin
					cmd.mul_go = 1'b1;
					ph_d = 1'b1;
				end else if (stat.mul_done) begin
					cmd.acc_add = 1'b1;
					ph_d = 1'b0;
					if (lj) st_d = ST_K0_LAM;
					else begin
						j_d = j_q + 1'b1;
						st_d = ST_K0_RD;
					end
				end
			end
			ST_K0_LAM: begin
				cmd.sel = SEL_ACCLAM;
				if (!ph_q) begin
					cmd.mul_go = 1'b1;
					ph_d = 1'b1;
				end else if (stat.mul_done) begin
					cmd.k0_wr = 1'b1;
					cmd.acc_clr = 1'b1;
					ph_d = 1'b0;
					j_d = '0;
					if (li) begin
						i_d = '0;
						st_d = ST_NU;
					end else begin
						i_d = i_q + 1'b1;
						st_d = ST_K0_RD;
					end
				end
			end
			ST_NU: begin
				cmd.sel = SEL_K0H;
				if (!ph_q) begin
					cmd.mul_go = 1'b1;
					ph_d = 1'b1;
				end else if (stat.mul_done) begin
					cmd.acc_add = 1'b1;
					ph_d = 1'b0;
					if (lj) begin
						i_d = '0;
						j_d = '0;
						st_d = ST_DIV;
					end else begin
						i_d = i_q + 1'b1;
						j_d = j_q + 1'b1;
					end
				end
			end
			ST_DIV: begin
				if (!ph_q) begin
					cmd.div_go = 1'b1;
					ph_d = 1'b1;
				end else if (stat.div_done) begin
					ph_d = 1'b0;
					st_d = ST_K1;
				end
			end
			ST_K1: begin
				cmd.sel = SEL_MUK0;
				if (!ph_q) begin
					cmd.mul_go = 1'b1;
					ph_d = 1'b1;
				end else if (stat.mul_done) begin
					cmd.k1_wr = 1'b1;
					ph_d = 1'b0;
					if (lj) begin
						i_d = '0;
						j_d = '0;
						st_d = ST_PU_RD;
					end else begin
						i_d = i_q + 1'b1;
						j_d = j_q + 1'b1;
					end
				end
			end
			ST_PU_RD: begin
				cmd.p_rd = 1'b1;
				st_d = ST_PU_M1;
			end
			ST_PU_M1: begin
				cmd.sel = SEL_PLAM;
				if (!ph_q) begin
					cmd.mul_go = 1'b1;
					ph_d = 1'b1;
				end else if (stat.mul_done) begin
					cmd.t1_wr = 1'b1;
					ph_d = 1'b0;
					st_d = ST_PU_M2;
				end
			end
			ST_PU_M2, ST_PU_WR2: begin
				cmd.sel = SEL_K1K0;
				if (st_q == ST_PU_M2 && !ph_q) begin
					cmd.mul_go = 1'b1;
					ph_d = 1'b1;
				end else if (st_q == ST_PU_WR2 || stat.mul_done) begin
					ph_d = 1'b0;
					if (st_q == ST_PU_M2) cmd.p_wr_lo = 1'b1;
					else cmd.p_wr_hi = 1'b1;
					if (st_q == ST_PU_M2 && i_q != j_q) begin
						st_d = ST_PU_WR2;
					end else if (j_q == i_q) begin
						j_d = '0;
						if (li) begin
							i_d = '0;
							st_d = ST_E0;
						end else begin
							i_d = i_q + 1'b1;
							st_d = ST_PU_RD;
						end
					end else begin
						j_d = j_q + 1'b1;
						st_d = ST_PU_RD;
					end
				end
			end
			ST_E0: begin
				cmd.e0_wr = 1'b1;
				cmd.acc_clr = 1'b1;
				st_d = ST_W;
			end
			ST_W: begin
				cmd.sel = SEL_E0K1;
				if (!ph_q) begin
					cmd.mul_go = 1'b1;
					ph_d = 1'b1;
				end else if (stat.mul_done) begin
					cmd.w_wr = 1'b1;
					ph_d = 1'b0;
					if (li) begin
						cmd.hist_shift = 1'b1;
						i_d = '0;
						j_d = '0;
						st_d = ST_EST;
					end else begin
						i_d = i_q + 1'b1;
						j_d = j_q + 1'b1;
					end
				end
			end
			ST_EST: begin
				cmd.sel = SEL_WH;
				if (!ph_q) begin
					cmd.mul_go = 1'b1;
					ph_d = 1'b1;
				end else if (stat.mul_done) begin
					cmd.acc_add = 1'b1;
					ph_d = 1'b0;
					if (li) st_d = ST_FIN;
					else begin
						i_d = i_q + 1'b1;
						j_d = j_q + 1'b1;
					end
				end
			end
			ST_FIN: begin
				cmd.est_wr = 1'b1;
				st_d = ST_OUT;
			end
			ST_OUT: begin
				if (!stat.out_full) begin
					cmd.out_load = 1'b1;
					st_d = ST_IDLE;
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			ph_q <= 1'b0;
			i_q <= '0;
			j_q <= '0;
		end else begin
			st_q <= st_d;
			ph_q <= ph_d;
			i_q <= i_d;
			j_q <= j_d;
		end
	end

	assign rdy = st_q == ST_IDLE;
	assign i = i_q;
	assign j = j_q;
endmodule
`default_nettype wire

// ===== tb/rls_adaptive_predictor_tb.sv =====
// Self-checking testbench of the RLS adaptive predictor: directed and random samples and register settings.
`default_nettype none
module rls_adaptive_predictor_tb
	import rls_pkg::*;
();
	localparam int NT = 4;
	localparam longint LIMIT = 4000000;
	localparam logic [3:0] ADDR_INV_FORGET = 4'h0;
	localparam logic [3:0] ADDR_P_INIT = 4'h4;
	localparam logic [3:0] ADDR_WARMUP = 4'h8;
	localparam logic [3:0] ADDR_UNUSED = 4'hC;

	typedef struct packed {
		logic [30:0] forecast;
		logic        in_warmup;
	} forecast_t;

	logic clk = 0, arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0, prdata;
	logic pready;
	logic s_tvalid = 0, s_tready;
	logic [31:0] s_tdata = '0;
	logic m_tvalid, m_tready = 0;
	logic [31:0] m_tdata;
	logic m_tuser;

	rls_adaptive_predictor uut (.*);

	// predictor state
	logic [31:0] lam_q30;
	logic [30:0] p_diag;
	logic [15:0] warm_len;
	longint pm[NT*NT];
	longint wt[NT];
	longint hist[NT];
	longint est;
	longint warm_cnt;

	// field extremes and bit patterns
	logic [31:0] corner_vals [9] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF,
		32'h1, 32'h0001_0000, 32'hFFFF_0000, 32'h5555_5555, 32'hAAAA_AAAA};

	logic [31:0] sample_q[$];
	forecast_t forecast_q[$];
	int errors = 0, n_results = 0, n_warm = 0, n_zero = 0;
	longint cycles = 0;
	bit quiet = 0, hold_off = 0, sat_seen = 0;
	int src_gap = 0, snk_gap = 0;
	logic [31:0] pend;

	initial forever #2 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("timeout at %0t", $time);
			$display("Mismatches found");
			$finish;
		end
	end

	function automatic longint clamp48(longint v);
		if (v > 64'sh7FFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF;
		if (v < -64'sh8000_0000_0000) return -64'sh8000_0000_0000;
		return v;
	endfunction

	function automatic longint mul_round(longint a, longint b, int sh);
		logic signed [127:0] p;
		logic [127:0] m;
		bit neg;
		p = 128'(signed'(a)) * 128'(signed'(b));
		neg = p[127];
		m = neg ? -p : p;
		m = (m + (128'd1 << (sh - 1))) >> sh;
		if (neg) begin
			if (m > 128'h8000_0000_0000) m = 128'h8000_0000_0000;
			return -longint'(m[63:0]);
		end
		if (m > 128'h7FFF_FFFF_FFFF) m = 128'h7FFF_FFFF_FFFF;
		return longint'(m[63:0]);
	endfunction

	function automatic void reload_matrix();
		for (int i = 0; i < NT*NT; i++) pm[i] = 0;
		for (int i = 0; i < NT; i++) pm[i*NT+i] = longint'(p_diag) << 16;
	endfunction

	function automatic forecast_t predict(logic [31:0] raw);
		longint k0[NT], k1[NT];
		longint s, acc, nu, den, mu, e0, lam, v;
		logic [63:0] d, q;
		forecast_t r;
		s = longint'(signed'(raw));
		lam = longint'(lam_q30);
		for (int i = 0; i < NT; i++) begin
			acc = 0;
			for (int j = 0; j < NT; j++) acc += mul_round(pm[i*NT+j], hist[j], 16);
			k0[i] = mul_round(clamp48(acc), lam, 30);
		end
		acc = 0;
		for (int i = 0; i < NT; i++) acc += mul_round(k0[i], hist[i], 16);
		nu = clamp48(acc);
		den = 64'sh1_0000_0000 + nu;
		if (den == 0) mu = 64'sh7FFF_FFFF_FFFF;
		else begin
			d = den < 0 ? -den : den;
			if (d < 64'h20000) begin
				q = 64'h7FFF_FFFF_FFFF;
				sat_seen = 1;
			end else begin
				q = 64'hFFFF_FFFF_FFFF_FFFF / d;
				if (64'hFFFF_FFFF_FFFF_FFFF % d == d - 1) q++;
				if (q > 64'h7FFF_FFFF_FFFF) q = 64'h7FFF_FFFF_FFFF;
			end
			mu = den < 0 ? -longint'(q) : longint'(q);
		end
		for (int i = 0; i < NT; i++) k1[i] = mul_round(mu, k0[i], 32);
		for (int i = 0; i < NT; i++)
			for (int j = 0; j <= i; j++) begin
				v = clamp48(mul_round(pm[i*NT+j], lam, 30) - mul_round(k1[i], k0[j], 32));
				pm[i*NT+j] = v;
				pm[j*NT+i] = v;
			end
		e0 = clamp48(s * 65536 - est);
		for (int i = 0; i < NT; i++) wt[i] = clamp48(wt[i] + mul_round(e0, k1[i], 32));
		for (int i = NT - 1; i > 0; i--) hist[i] = hist[i-1];
		hist[0] = s;
		acc = 0;
		for (int i = 0; i < NT; i++) acc += mul_round(wt[i], hist[i], 16);
		est = clamp48(acc);
		if (warm_cnt < longint'(warm_len)) begin
			warm_cnt++;
			r.in_warmup = 1;
			r.forecast = s > 0 ? 31'(s) : '0;
		end else begin
			r.in_warmup = 0;
			if (est <= 0) r.forecast = '0;
			else begin
				v = (est + 64'h8000) >>> 16;
				r.forecast = v > 64'h7FFF_FFFF ? 31'h7FFF_FFFF : 31'(v);
			end
		end
		return r;
	endfunction

	// sample driver
	always @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			forecast_q = {forecast_q, predict(s_tdata)};
			sample_q.delete(0);
		end
		if (!s_tvalid || s_tready) begin
			pend = sample_q.size() ? sample_q[0] : '0;
			if (src_gap > 0) begin
				src_gap <= src_gap - 1;
				s_tvalid <= 0;
			end else if (sample_q.size() > 0) begin
				if (!quiet && $urandom_range(0, 7) == 0) begin
					src_gap <= $urandom_range(1, 9);
					s_tvalid <= 0;
				end else begin
					s_tvalid <= 1;
					s_tdata <= pend;
				end
			end else s_tvalid <= 0;
		end
	end

	// result monitor
	always @(posedge clk) begin
		forecast_t got, want;
		if (m_tvalid && m_tready) begin
			got.forecast = m_tdata[30:0];
			got.in_warmup = m_tuser;
			n_results++;
			if (got.in_warmup) n_warm++;
			if (got.forecast == 0) n_zero++;
			if (forecast_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected word %h/%b", $time, m_tdata, m_tuser);
			end else begin
				want = forecast_q[0];
				forecast_q.delete(0);
				if (got.forecast !== want.forecast || m_tdata[31] !== 1'b0) begin
					errors++;
					$display("%0t: forecast expected %h actual %h", $time,
						want.forecast, m_tdata);
				end
				if (got.in_warmup !== want.in_warmup) begin
					errors++;
					$display("%0t: in_warmup expected %b actual %b", $time,
						want.in_warmup, got.in_warmup);
				end
			end
		end
		if (hold_off) m_tready <= 0;
		else if (snk_gap > 0) begin
			snk_gap <= snk_gap - 1;
			m_tready <= 0;
		end else if (!quiet && $urandom_range(0, 7) == 0) begin
			snk_gap <= $urandom_range(1, 9);
			m_tready <= 0;
		end else m_tready <= 1;
	end

	task automatic reg_write(logic [3:0] a, logic [31:0] d);
		@(posedge clk);
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= a; pwdata <= d;
		@(posedge clk);
		penable <= 1;
		do @(posedge clk); while (!pready);
		psel <= 0; penable <= 0; pwrite <= 0;
		case (a)
			ADDR_INV_FORGET: lam_q30 = d;
			ADDR_P_INIT: begin
				p_diag = d[30:0];
				reload_matrix();
			end
			ADDR_WARMUP: warm_len = d[15:0];
			default: ;
		endcase
	endtask

	task automatic drain();
		while (sample_q.size() || forecast_q.size() || s_tvalid) @(posedge clk);
		repeat (600) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_sample();
		case ($urandom_range(0, 9))
			0: return $urandom;
			1: return 32'($urandom_range(0, 20)) << 16;
			2: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
			default: return 32'($urandom_range(0, 600) << 10) + 32'($urandom_range(0, 1023));
		endcase
	endfunction

	task automatic run_phase(int n);
		for (int i = 0; i < n; i++) sample_q = {sample_q, rand_sample()};
		drain();
	endtask

	initial begin
		lam_q30 = INV_FORGET_RST;
		p_diag = P_INIT_RST;
		warm_len = WARMUP_RST;
		reload_matrix();
		for (int i = 0; i < NT; i++) begin
			wt[i] = 0;
			hist[i] = 0;
		end
		est = 0;
		warm_cnt = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		repeat (2) @(posedge clk);

		// directed: field extremes, zero, small repeating ramp past warmup
		for (int i = 0; i < 9; i++) sample_q = {sample_q, corner_vals[i]};
		for (int i = 0; i < 12; i++) sample_q = {sample_q, 32'((i % 4 + 1) << 16)};
		drain();

		// registers at extremes; unknown address ignored
		reg_write(ADDR_INV_FORGET, 32'h4000_0000);
		reg_write(ADDR_P_INIT, 32'h0000_0001);
		reg_write(ADDR_WARMUP, 32'd0);
		reg_write(ADDR_UNUSED, $urandom);
		run_phase(150);

		// receiver holds off while samples keep coming
		hold_off = 1;
		for (int i = 0; i < 20; i++) sample_q = {sample_q, rand_sample()};
		repeat (3000) @(posedge clk);
		hold_off = 0;
		drain();

		reg_write(ADDR_INV_FORGET, 32'hFFFF_FFFF);
		reg_write(ADDR_P_INIT, 32'h7FFF_FFFF);
		reg_write(ADDR_WARMUP, 32'hFFFF);
		run_phase(100);
		reg_write(ADDR_WARMUP, 32'd3);
		reg_write(ADDR_P_INIT, 32'h0064_0000);
		reg_write(ADDR_INV_FORGET, INV_FORGET_RST);
		run_phase(300);
		reg_write(ADDR_INV_FORGET, 32'($urandom_range(32'h4000_0000, 32'h4800_0000)));
		reg_write(ADDR_P_INIT, 32'($urandom_range(1, 32'h0100_0000)));
		reg_write(ADDR_WARMUP, 32'($urandom_range(0, 40)));
		run_phase(350);
		reg_write(ADDR_P_INIT, P_INIT_RST);
		reg_write(ADDR_WARMUP, 32'd12);
		quiet = 1;
		run_phase(300);

		$display("%0d results, %0d pass-through, %0d clamped to zero, tiny divisor %0s",
			n_results, n_warm, n_zero, sat_seen ? "hit" : "not hit");
		if (errors == 0) $display("No mismatches found");
		else $display("Mismatches found");
		$finish;
	end
endmodule
`default_nettype wire

// ===== files.f =====
hdl/rls_pkg.sv
hdl/rls_mul.sv
hdl/rls_div.sv
hdl/rls_dp.sv
hdl/rls_ctrl.sv
hdl/rls_adaptive_predictor.sv
tb/rls_adaptive_predictor_tb.sv
